@@ design/lna_pkg.sv @@
// Shared types, constants and tables for the logarithmic number ALU.
// Used by lna_front, lna_queue, lna_back and log_number_alu_unit.
package lna_pkg;

  localparam logic [1:0] OP_MUL = 2'd0;
  localparam logic [1:0] OP_DIV = 2'd1;
  localparam logic [1:0] OP_ADD = 2'd2;
  localparam logic [1:0] OP_SUB = 2'd3;

  localparam logic [15:0] SIGN_BIT    = 16'h4000;
  localparam logic [15:0] CANCEL_WORD = 16'h8000;
  localparam logic [13:0] FAR_DIST    = 14'd524;
  localparam logic [7:0]  EQUAL_CORR  = 8'd77;
  localparam int          PREFIX_LEN  = 77;
  localparam int          QUEUE_DEPTH = 2;

  // How the back end finishes a request.
  typedef enum logic [1:0] {
    K_DIRECT,  // word is already the result
    K_EQUAL,   // equal magnitudes: add fixed correction
    K_OPP,     // opposite signs: band or near table correction
    K_SAME     // same signs: prefix sum count correction
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] word;
    logic [9:0]  span;
  } lna_item_t;

  localparam logic [9:0] ADD_PREFIX [PREFIX_LEN] = '{
    10'd2,   10'd4,   10'd6,   10'd8,   10'd10,  10'd12,  10'd14,  10'd16,
    10'd18,  10'd21,  10'd23,  10'd25,  10'd27,  10'd30,  10'd32,  10'd34,
    10'd37,  10'd39,  10'd42,  10'd44,  10'd47,  10'd49,  10'd52,  10'd54,
    10'd57,  10'd60,  10'd62,  10'd65,  10'd68,  10'd71,  10'd74,  10'd77,
    10'd80,  10'd83,  10'd86,  10'd89,  10'd93,  10'd96,  10'd99,  10'd103,
    10'd106, 10'd110, 10'd114, 10'd118, 10'd122, 10'd126, 10'd130, 10'd134,
    10'd139, 10'd143, 10'd148, 10'd153, 10'd158, 10'd163, 10'd168, 10'd174,
    10'd180, 10'd186, 10'd193, 10'd200, 10'd207, 10'd215, 10'd223, 10'd232,
    10'd241, 10'd251, 10'd262, 10'd274, 10'd287, 10'd302, 10'd319, 10'd338,
    10'd360, 10'd386, 10'd419, 10'd463, 10'd539
  };

  localparam logic [7:0] NEAR_CORR [36] = '{
    8'd255, 8'd192, 8'd147, 8'd116, 8'd91,  8'd72,  8'd55,  8'd41,
    8'd28,  8'd17,  8'd7,   8'd254, 8'd247, 8'd241, 8'd235, 8'd230,
    8'd225, 8'd220, 8'd216, 8'd211, 8'd207, 8'd203, 8'd199, 8'd196,
    8'd192, 8'd189, 8'd186, 8'd183, 8'd180, 8'd177, 8'd174, 8'd171,
    8'd169, 8'd166, 8'd164, 8'd161
  };

  // Correction for opposite signs; d is 1..523.
  function automatic logic [7:0] opp_corr(input logic [9:0] d);
    logic [5:0] idx;
    idx = 6'(d - 10'd1);
    priority if (d >= 10'd446) opp_corr = 8'd255;
    else if (d >= 10'd347)     opp_corr = 8'd254;
    else if (d >= 10'd256)     opp_corr = 8'd244;
    else if (d >= 10'd143)     opp_corr = 8'd214;
    else if (d >= 10'd93)      opp_corr = 8'd163;
    else if (d >= 10'd63)      opp_corr = 8'd131;
    else if (d >= 10'd37)      opp_corr = 8'd114;
    else                       opp_corr = NEAR_CORR[idx];
  endfunction

endpackage

@@ design/lna_front.sv @@
// Front end: decodes the operation, finishes multiply and divide, orders
// add operands and classifies the add case. Depends on lna_pkg.
module lna_front import lna_pkg::*; (
  input  logic [1:0]  operation,
  input  logic [15:0] operand_a,
  input  logic [15:0] operand_b,
  output lna_item_t   item
);

  logic [15:0] b_eff;
  logic [15:0] big;
  logic [15:0] small_w;
  logic [13:0] diff;
  logic [15:0] mul_sum;
  logic [15:0] div_diff;
  logic [15:0] mul_word;
  logic [15:0] div_word;

  assign b_eff    = (operation == OP_SUB) ? (operand_b ^ SIGN_BIT) : operand_b;
  assign big      = (operand_a[13:0] > b_eff[13:0]) ? operand_a : b_eff;
  assign small_w  = (operand_a[13:0] > b_eff[13:0]) ? b_eff : operand_a;
  assign diff     = big[13:0] - small_w[13:0];
  assign mul_sum  = operand_a + operand_b;
  assign div_diff = operand_a - operand_b;
  assign mul_word = {1'b1, mul_sum[14] ^ mul_sum[15], mul_sum[13:0]};
  assign div_word = {1'b1, div_diff[14] ^ ~div_diff[15], div_diff[13:0]};

  always_comb begin
    item.span = diff[9:0];
    item.word = big;
    item.kind = K_DIRECT;
    unique case (operation)
      OP_MUL: item.word = mul_word;
      OP_DIV: item.word = div_word;
      OP_ADD, OP_SUB: begin
        priority if ((operand_a ^ b_eff) == SIGN_BIT) item.word = CANCEL_WORD;
        else if (diff >= FAR_DIST)                     item.kind = K_DIRECT;
        else if (diff == '0)                           item.kind = K_EQUAL;
        else if (operand_a[14] ^ b_eff[14])            item.kind = K_OPP;
        else                                           item.kind = K_SAME;
      end
      default: item.word = mul_word;
    endcase
  end

endmodule

@@ design/lna_queue.sv @@
// Short request queue between front and back end.
// Depends on lna_pkg for the entry type and depth.
module lna_queue import lna_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  lna_item_t push_item,
  input  logic      pop,
  output lna_item_t head,
  output logic      not_empty,
  output logic      full
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  lna_item_t      entries [QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  assign not_empty = (count != '0);
  assign full      = (count == CW'(QUEUE_DEPTH));
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CW'(push) - CW'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("request pushed into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> not_empty)
    else $error("request popped from empty queue");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(QUEUE_DEPTH))
    else $error("queue count beyond depth");
  a_push_lands: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> not_empty)
    else $error("pushed request lost");

endmodule

@@ design/lna_back.sv @@
// Back end: applies the add-path correction and registers the result.
// Depends on lna_pkg for the entry type and correction tables.
module lna_back import lna_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  lna_item_t   in_item,
  output logic        done,
  output logic [15:0] result_word
);

  logic [6:0]  cnt;
  logic [7:0]  corr;
  logic [8:0]  sum;
  logic [5:0]  exp_in;
  logic [5:0]  exp_out;
  logic [15:0] res;

  // Count prefix sums at or below the distance, all in parallel.
  always_comb begin
    cnt = '0;
    for (int i = 0; i < PREFIX_LEN; i++) begin
      cnt = cnt + 7'(ADD_PREFIX[i] <= in_item.span);
    end
  end

  always_comb begin
    unique case (in_item.kind)
      K_EQUAL: corr = EQUAL_CORR;
      K_OPP:   corr = opp_corr(in_item.span);
      K_SAME:  corr = EQUAL_CORR - {1'b0, cnt};
      default: corr = '0;
    endcase
  end

  assign sum    = {1'b0, in_item.word[7:0]} + {1'b0, corr};
  assign exp_in = in_item.word[13:8];

  // Opposite signs subtract 256-c: no carry out means a borrow.
  always_comb begin
    unique case (in_item.kind)
      K_OPP:   exp_out = sum[8] ? exp_in : exp_in - 6'd1;
      K_DIRECT: exp_out = exp_in;
      default: exp_out = sum[8] ? exp_in + 6'd1 : exp_in;
    endcase
    res = (in_item.kind == K_DIRECT) ? in_item.word
                                     : {in_item.word[15:14], exp_out, sum[7:0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
    if (in_valid) begin
      result_word <= res;
    end
  end

endmodule

@@ design/log_number_alu_unit.sv @@
// Top level of the 16-bit logarithmic number ALU.
// Depends on lna_pkg, lna_front, lna_queue and lna_back.
//
// Usage:
//   Drive operation, operand_a and operand_b with start high; the request
//   is taken at a rising edge where busy is low. Operations: multiply,
//   divide, add, subtract on words with tag, sign, biased exponent and
//   fraction.
//   The front end classifies the request and writes it into a two-entry
//   queue at that edge. The back end takes one request a cycle from the
//   queue, applies the table correction and registers the result.
//   The back end registers the result at the edge after the accepting one;
//   done and result_word hold it for the next cycle, and it is taken at the
//   end of that cycle.
//   Throughput: one request per cycle; the back end drains one entry every
//   cycle, so the queue never holds more than one request and busy stays low.
//   The receiver cannot stall: each result must be taken while done is high.
//   Reset (rst, synchronous, active high) empties the queue and clears done;
//   requests in flight are dropped.
module log_number_alu_unit import lna_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  operation,
  input  logic [15:0] operand_a,
  input  logic [15:0] operand_b,
  output logic        done,
  output logic [15:0] result_word
);

  lna_item_t front_item;
  lna_item_t head;
  logic      push;
  logic      not_empty;
  logic      full;

  assign busy = full;
  assign push = start && !busy;

  lna_front u_front (
    .operation (operation),
    .operand_a (operand_a),
    .operand_b (operand_b),
    .item      (front_item)
  );

  lna_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (front_item),
    .pop       (not_empty),
    .head      (head),
    .not_empty (not_empty),
    .full      (full)
  );

  lna_back u_back (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (not_empty),
    .in_item     (head),
    .done        (done),
    .result_word (result_word)
  );

endmodule

@@ bench/log_number_alu_checker.sv @@
// Result checker for the logarithmic number ALU: watches requests and results,
// predicts every result word and compares it. Depends on lna_pkg only.
`timescale 1ns / 1ps

module lna_result_checker import lna_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  operation,
  input  logic [15:0] operand_a,
  input  logic [15:0] operand_b,
  input  logic        done,
  input  logic [15:0] result_word,
  output int          pending,
  output int          mismatches
);

  typedef struct {
    logic [1:0]  op;
    logic [15:0] a;
    logic [15:0] b;
    logic [15:0] word;
  } lna_expect_t;

  localparam logic [9:0] STEP_SUMS [77] = '{
    10'd2,   10'd4,   10'd6,   10'd8,   10'd10,  10'd12,  10'd14,  10'd16,
    10'd18,  10'd21,  10'd23,  10'd25,  10'd27,  10'd30,  10'd32,  10'd34,
    10'd37,  10'd39,  10'd42,  10'd44,  10'd47,  10'd49,  10'd52,  10'd54,
    10'd57,  10'd60,  10'd62,  10'd65,  10'd68,  10'd71,  10'd74,  10'd77,
    10'd80,  10'd83,  10'd86,  10'd89,  10'd93,  10'd96,  10'd99,  10'd103,
    10'd106, 10'd110, 10'd114, 10'd118, 10'd122, 10'd126, 10'd130, 10'd134,
    10'd139, 10'd143, 10'd148, 10'd153, 10'd158, 10'd163, 10'd168, 10'd174,
    10'd180, 10'd186, 10'd193, 10'd200, 10'd207, 10'd215, 10'd223, 10'd232,
    10'd241, 10'd251, 10'd262, 10'd274, 10'd287, 10'd302, 10'd319, 10'd338,
    10'd360, 10'd386, 10'd419, 10'd463, 10'd539
  };

  localparam logic [7:0] CLOSE_DIFF [36] = '{
    8'd255, 8'd192, 8'd147, 8'd116, 8'd91,  8'd72,  8'd55,  8'd41,
    8'd28,  8'd17,  8'd7,   8'd254, 8'd247, 8'd241, 8'd235, 8'd230,
    8'd225, 8'd220, 8'd216, 8'd211, 8'd207, 8'd203, 8'd199, 8'd196,
    8'd192, 8'd189, 8'd186, 8'd183, 8'd180, 8'd177, 8'd174, 8'd171,
    8'd169, 8'd166, 8'd164, 8'd161
  };

  lna_expect_t expect_q[$];
  int          errors = 0;

  // Log-domain addition: correct the larger word's fraction, carry or borrow into the exponent.
  function automatic logic [15:0] log_sum(input logic [15:0] a, input logic [15:0] b);
    logic [15:0] greater;
    logic [15:0] lesser;
    logic [13:0] span;
    logic [8:0]  frac;
    logic [7:0]  corr;
    logic [5:0]  expo;
    int          steps;
    if (a[13:0] > b[13:0]) begin
      greater = a;
      lesser  = b;
    end else begin
      greater = b;
      lesser  = a;
    end
    if ((a ^ b) == SIGN_BIT) return CANCEL_WORD;
    span = greater[13:0] - lesser[13:0];
    if (span >= FAR_DIST) return greater;
    expo = greater[13:8];
    if (span == 14'd0) begin
      frac = {1'b0, greater[7:0]} + {1'b0, EQUAL_CORR};
      if (frac[8]) expo = expo + 6'd1;
    end else if (((a ^ b) & SIGN_BIT) != 16'd0) begin
      if (span >= 14'd446)      corr = 8'd255;
      else if (span >= 14'd347) corr = 8'd254;
      else if (span >= 14'd256) corr = 8'd244;
      else if (span >= 14'd143) corr = 8'd214;
      else if (span >= 14'd93)  corr = 8'd163;
      else if (span >= 14'd63)  corr = 8'd131;
      else if (span >= 14'd37)  corr = 8'd114;
      else                      corr = CLOSE_DIFF[6'(span - 14'd1)];
      // frac - (256 - corr): no carry out of frac + corr means a borrow
      frac = {1'b0, greater[7:0]} + {1'b0, corr};
      if (!frac[8]) expo = expo - 6'd1;
    end else begin
      steps = 0;
      for (int i = 0; i < 77; i++)
        if ({4'd0, STEP_SUMS[i]} <= span) steps++;
      frac = {1'b0, greater[7:0]} + 9'(77 - steps);
      if (frac[8]) expo = expo + 6'd1;
    end
    return {greater[15:14], expo, frac[7:0]};
  endfunction

  function automatic logic [15:0] predict_word(input logic [1:0] op, input logic [15:0] a,
                                               input logic [15:0] b);
    logic [15:0] r;
    case (op)
      OP_MUL: begin
        r = a + b;
        if (r[15]) r[14] = ~r[14];
        r[15] = 1'b1;
      end
      OP_DIV: begin
        r = a - b;
        if (!r[15]) r[14] = ~r[14];
        r[15] = 1'b1;
      end
      OP_ADD:  r = log_sum(a, b);
      default: r = log_sum(a, b ^ SIGN_BIT);
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    lna_expect_t item;
    if (rst) begin
      expect_q.delete();
    end else begin
      if (start && !busy) begin
        item.op   = operation;
        item.a    = operand_a;
        item.b    = operand_b;
        item.word = predict_word(operation, operand_a, operand_b);
        expect_q.push_back(item);
      end
      if (done) begin
        if (expect_q.size() == 0) begin
          $display("%0t unexpected result: expected none, actual %h", $time, result_word);
          errors++;
        end else begin
          item = expect_q.pop_front();
          if (result_word !== item.word) begin
            $display("%0t result_word mismatch (op %0d a %h b %h): expected %h, actual %h",
                     $time, item.op, item.a, item.b, item.word, result_word);
            errors++;
          end
        end
      end
    end
    pending    <= expect_q.size();
    mismatches <= errors;
  end

endmodule

@@ bench/log_number_alu_unit_tb.sv @@
// Top of the logarithmic number ALU testbench: clock, reset and request stimulus.
// Depends on lna_pkg, log_number_alu_unit and lna_result_checker.
`timescale 1ns / 1ps

module log_number_alu_unit_tb;
  import lna_pkg::*;

  localparam int CYCLE_LIMIT  = 100000;
  localparam int RANDOM_ITEMS = 650;

  logic        clk;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [1:0]  operation = OP_MUL;
  logic [15:0] operand_a = 16'd0;
  logic [15:0] operand_b = 16'd0;
  logic        busy;
  logic        done;
  logic [15:0] result_word;
  int          pending;
  int          mismatches;
  int          cycle_count = 0;
  bit          steady = 1'b0;

  log_number_alu_unit dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .operation   (operation),
    .operand_a   (operand_a),
    .operand_b   (operand_b),
    .done        (done),
    .result_word (result_word)
  );

  lna_result_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .operation   (operation),
    .operand_a   (operand_a),
    .operand_b   (operand_b),
    .done        (done),
    .result_word (result_word),
    .pending     (pending),
    .mismatches  (mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Unless steady, idle for a random gap; then hold the request until an edge with busy low takes it.
  task automatic send_request(input logic [1:0] op, input logic [15:0] a,
                              input logic [15:0] b);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start     <= 1'b1;
    operation <= op;
    operand_a <= a;
    operand_b <= b;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    logic [1:0]  op;
    logic [15:0] a;
    logic [15:0] b;
    int          offs;
    int          pick;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    send_request(OP_MUL, 16'h0000, 16'h0000);
    send_request(OP_MUL, 16'hFFFF, 16'hFFFF);
    send_request(OP_MUL, 16'hC000, 16'h8001);
    send_request(OP_DIV, 16'hFFFF, 16'h0000);
    send_request(OP_DIV, 16'h0000, 16'hFFFF);
    send_request(OP_DIV, 16'h8000, 16'hC0FF);
    send_request(OP_ADD, 16'hC123, 16'h8123);  // opposite signs, same magnitude
    send_request(OP_SUB, 16'hC123, 16'hC123);  // same after the sign flip
    send_request(OP_ADD, 16'h8000, 16'h820C);  // just far apart
    send_request(OP_ADD, 16'h8000, 16'h820B);  // just inside the table range
    send_request(OP_ADD, 16'hBFFF, 16'hBFFF);  // equal, exponent wraps upward
    send_request(OP_ADD, 16'h00C0, 16'h80C0);  // equal magnitude, tags differ
    send_request(OP_ADD, 16'h8100, 16'hC101);
    send_request(OP_ADD, 16'h8100, 16'hC124);
    send_request(OP_ADD, 16'h8100, 16'hC125);
    send_request(OP_ADD, 16'h8000, 16'hC1BE);
    send_request(OP_ADD, 16'h8000, 16'hC1BD);
    send_request(OP_SUB, 16'h8000, 16'h800B);  // borrow wraps exponent downward
    send_request(OP_ADD, 16'h8000, 16'h8001);
    send_request(OP_SUB, 16'hFFFF, 16'h7FFF);
    send_request(OP_ADD, 16'h4000, 16'h0000);
    send_request(OP_SUB, 16'h3FFF, 16'hFFFF);
    drain_results();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 50 == 0) steady = ($urandom_range(0, 3) == 0);
      // pause once until the pipeline is empty
      if (n == RANDOM_ITEMS / 2) drain_results();
      pick = $urandom_range(0, 99);
      a = 16'($urandom);
      b = 16'($urandom);
      op = 2'($urandom);
      if (pick < 25) begin
        op = $urandom_range(0, 1) ? OP_MUL : OP_DIV;
      end else if (pick < 85) begin
        op = $urandom_range(0, 1) ? OP_ADD : OP_SUB;
        if ($urandom_range(0, 1))
          offs = int'($urandom_range(0, 80)) - 40;
        else
          offs = int'($urandom_range(0, 1200)) - 600;
        b[13:0] = 14'(int'(a[13:0]) + offs);
        if ($urandom_range(0, 15) == 0) b = (op == OP_ADD) ? (a ^ SIGN_BIT) : a;
      end
      send_request(op, a, b);
    end
    drain_results();
    repeat (10) @(posedge clk);

    if (mismatches == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
